>>> design/rfps_pkg.sv
// Package for the range frame parser and smoother.
// Holds widths, reset values, codes and the types shared between the design files.
// No dependencies.
package rfps_pkg;

	// Defaults for the top-level parameters
	localparam int PAYLOAD_BYTES_DEF = 4;
	localparam int FRACTION_BITS_DEF = 8;

	// Frame header and byte framing
	localparam logic [23:0] HDR_PATTERN = 24'hB46904;
	localparam int          COUNT_W     = 3;

	// Configuration port
	localparam int          CFG_IDX_W         = 4;
	localparam int          CFG_DATA_W        = 24;
	localparam logic [CFG_IDX_W-1:0] REG_OUTLIER_LIMIT    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_WEIGHT = CFG_IDX_W'(1);

	localparam int          LIMIT_W           = 24;
	localparam int          WEIGHT_W          = 9;
	localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 24'd1000;
	localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 9'd179;
	localparam logic [WEIGHT_W-1:0] WEIGHT_FULL  = 9'd256;

	// Q8 rounding term
	localparam int          Q8_SHIFT = 8;
	localparam int          Q8_HALF  = 128;

	// Result queue depth
	localparam int          QUEUE_DEPTH = 2;
	localparam int          QCOUNT_W    = 2;

	typedef struct packed {
		logic               valid;
		logic signed [31:0] distance;
	} frame_t;

	typedef struct packed {
		logic signed [31:0] distance_mm;
		logic [7:0]         distance_fraction;
		logic               outlier_dropped;
		logic               was_first_frame;
	} result_t;

	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
	} filt_status_t;

endpackage

>>> design/rfps_if.sv
// Handshake channels of the range frame parser and smoother.
// Byte input, result output and configuration write. Uses rfps_pkg.

interface rfps_byte_if
	import rfps_pkg::*;
	();
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rfps_result_if
	import rfps_pkg::*;
	();
	logic               valid;
	logic               ready;
	logic signed [31:0] distance_mm;
	logic [7:0]         distance_fraction;
	logic               outlier_dropped;
	logic               was_first_frame;

	modport source (output valid, output distance_mm, output distance_fraction,
		output outlier_dropped, output was_first_frame, input ready);
	modport sink   (input valid, input distance_mm, input distance_fraction,
		input outlier_dropped, input was_first_frame, output ready);
endinterface

interface rfps_cfg_if
	import rfps_pkg::*;
	();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/rfps_parser.sv
// Header hunt and payload gather for the range frame parser.
// Emits one registered frame per completed payload. Uses rfps_pkg.
module rfps_parser
	import rfps_pkg::*;
#(
	parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_acc,
	input  logic [7:0] rx_byte,
	output frame_t     frame_s1
);

	logic [23:0]        header_window_q;
	logic               in_payload_q;
	logic [COUNT_W-1:0] payload_count_q;
	logic [31:0]        raw_acc_q;

	logic [23:0]        window_next;
	logic [31:0]        acc_next;
	logic [COUNT_W-1:0] count_next;
	logic               frame_done;

	assign window_next = {header_window_q[15:0], rx_byte};
	assign acc_next    = {raw_acc_q[23:0], rx_byte};
	assign count_next  = payload_count_q + COUNT_W'(1);
	assign frame_done  = byte_acc && in_payload_q && (count_next == COUNT_W'(PAYLOAD_BYTES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_window_q   <= '0;
			in_payload_q      <= 1'b0;
			payload_count_q   <= '0;
			raw_acc_q         <= '0;
			frame_s1.valid    <= 1'b0;
			frame_s1.distance <= '0;
		end else begin
			frame_s1.valid <= frame_done;
			if (byte_acc) begin
				if (!in_payload_q) begin
					header_window_q <= window_next;
					if (window_next == HDR_PATTERN) begin
						in_payload_q    <= 1'b1;
						payload_count_q <= '0;
						raw_acc_q       <= '0;
					end
				end else if (frame_done) begin
					// frame complete: resume hunting from a clean window
					in_payload_q      <= 1'b0;
					payload_count_q   <= '0;
					header_window_q   <= '0;
					raw_acc_q         <= acc_next;
					frame_s1.distance <= $signed(acc_next);
				end else begin
					payload_count_q <= count_next;
					raw_acc_q       <= acc_next;
				end
			end
		end
	end

	a_frame_ends_payload: assert property (@(posedge clk) disable iff (!arst_n)
		frame_s1.valid |-> !in_payload_q && header_window_q == 24'd0)
		else $error("parser still in payload after a completed frame");

endmodule

>>> design/rfps_filter.sv
// Outlier replacement and exponential smoothing of parsed distances.
// Three pipeline stages after the parser register. Uses rfps_pkg.
module rfps_filter
	import rfps_pkg::*;
#(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  frame_t              frame_s1,
	input  logic [LIMIT_W-1:0]  outlier_limit,
	input  logic [WEIGHT_W-1:0] smoothing_weight,
	output logic                res_valid,
	output result_t             res,
	output filt_status_t        status
);

	localparam int SW   = 32 + FRACTION_BITS;
	localparam int PW   = SW + 10;
	localparam int SUMW = SW + 11;
	localparam int DW   = 34;

	// stage 2: outlier decision
	logic               v_s2, first_s2, dropped_s2;
	logic signed [31:0] x_s2;
	logic signed [31:0] last_accepted_q;
	logic               awaiting_first_q;

	// stage 3: products
	logic               v_s3, first_s3, dropped_s3;
	logic signed [31:0] x_s3;
	logic signed [PW-1:0] p_new_s3, p_old_s3;

	// stage 4: smoothed value and flags
	logic               v_s4, first_s4, dropped_s4;
	logic signed [SW-1:0] smoothed_q;

	logic signed [DW-1:0]  diff;
	logic signed [DW-1:0]  lim_ext;
	logic                  is_outlier;
	logic [WEIGHT_W-1:0]   w_sat;
	logic [WEIGHT_W-1:0]   w_rest;
	logic signed [SW-1:0]  x_scaled_s2;
	logic signed [SUMW-1:0] sum;
	logic signed [SUMW-1:0] sum_sh;
	logic signed [SW-1:0]  s_next;
	logic signed [SW-1:0]  s_int;
	logic                  round_up;
	logic [FRACTION_BITS-1:0] frac;
	logic [FRACTION_BITS+7:0] frac_ext;

	assign diff       = DW'(frame_s1.distance) - DW'(last_accepted_q);
	assign lim_ext    = $signed({{(DW-LIMIT_W){1'b0}}, outlier_limit});
	assign is_outlier = (diff > lim_ext) || (-diff > lim_ext);

	assign w_sat  = (smoothing_weight > WEIGHT_FULL) ? WEIGHT_FULL : smoothing_weight;
	assign w_rest = WEIGHT_FULL - w_sat;
	assign x_scaled_s2 = SW'(x_s2) <<< FRACTION_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2             <= 1'b0;
			v_s3             <= 1'b0;
			v_s4             <= 1'b0;
			last_accepted_q  <= '0;
			awaiting_first_q <= 1'b1;
			smoothed_q       <= '0;
		end else begin
			v_s2 <= frame_s1.valid;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			if (frame_s1.valid) begin
				if (awaiting_first_q) begin
					awaiting_first_q <= 1'b0;
					last_accepted_q  <= frame_s1.distance;
				end else if (!is_outlier) begin
					last_accepted_q  <= frame_s1.distance;
				end
			end
			if (v_s3) begin
				smoothed_q <= s_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (frame_s1.valid) begin
			first_s2   <= awaiting_first_q;
			dropped_s2 <= !awaiting_first_q && is_outlier;
			// replace an outlier by the last accepted distance
			x_s2       <= (!awaiting_first_q && is_outlier) ? last_accepted_q
				: frame_s1.distance;
		end
		if (v_s2) begin
			first_s3   <= first_s2;
			dropped_s3 <= dropped_s2;
			x_s3       <= x_s2;
			p_new_s3   <= PW'($signed({1'b0, w_sat})) * PW'(x_scaled_s2);
			p_old_s3   <= PW'($signed({1'b0, w_rest})) * PW'(smoothed_q);
		end
		if (v_s3) begin
			first_s4   <= first_s3;
			dropped_s4 <= dropped_s3;
		end
	end

	// round to nearest, halves up, then floor by the arithmetic shift
	assign sum    = SUMW'(p_new_s3) + SUMW'(p_old_s3) + SUMW'(Q8_HALF);
	assign sum_sh = sum >>> Q8_SHIFT;
	assign s_next = first_s3 ? (SW'(x_s3) <<< FRACTION_BITS) : SW'(sum_sh);

	// integer part truncates toward zero, fraction is taken from the magnitude
	assign s_int    = smoothed_q >>> FRACTION_BITS;
	assign round_up = smoothed_q[SW-1] && (smoothed_q[FRACTION_BITS-1:0] != '0);
	assign frac     = smoothed_q[SW-1] ? (FRACTION_BITS'(0) - smoothed_q[FRACTION_BITS-1:0])
		: smoothed_q[FRACTION_BITS-1:0];
	assign frac_ext = {frac, 8'h00};

	assign res_valid             = v_s4;
	assign res.distance_mm       = s_int[31:0] + 32'(round_up);
	assign res.distance_fraction = frac_ext[FRACTION_BITS+7 -: 8];
	assign res.outlier_dropped   = dropped_s4;
	assign res.was_first_frame   = first_s4;

	assign status.s2 = v_s2;
	assign status.s3 = v_s3;
	assign status.s4 = v_s4;

	a_one_frame_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({frame_s1.valid, v_s2, v_s3, v_s4}))
		else $error("two frames in the filter pipeline at once");

endmodule

>>> design/rfps_result_queue.sv
// Two-entry result queue between the filter and the output channel.
// Uses rfps_pkg for the result type.
module rfps_result_queue
	import rfps_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  result_t             push_data,
	input  logic                pop,
	output logic                not_empty,
	output result_t             head,
	output logic [QCOUNT_W-1:0] count
);

	result_t             entries_q [QUEUE_DEPTH];
	logic                wr_ptr_q, rd_ptr_q;
	logic [QCOUNT_W-1:0] count_q;
	logic                do_pop;

	assign do_pop    = pop && (count_q != '0);
	assign not_empty = (count_q != '0);
	assign head      = entries_q[rd_ptr_q];
	assign count     = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + QCOUNT_W'(push) - QCOUNT_W'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != QCOUNT_W'(QUEUE_DEPTH)) || pop)
		else $error("result pushed into a full queue");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCOUNT_W'(QUEUE_DEPTH))
		else $error("result queue count out of range");

endmodule

>>> design/range_frame_parse_and_smooth.sv
// Range frame parser and smoother: one received byte per cycle in while the
// byte input is not stalled, one smoothed distance out per completed frame.
// The byte input stalls only when the two-entry result queue, together with a
// frame still in the parser register or the filter, would be full. A frame's
// result reaches the result queue through the parser register, outlier stage,
// multiplier stage and smoothing register, and is shown from the queue in the
// next cycle. Frames are at least seven bytes apart, so the filter state is
// always settled before the next frame reaches it.
// Depends on rfps_pkg, rfps_if and the rfps_* submodules.
module range_frame_parse_and_smooth
	import rfps_pkg::*;
#(
	parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	rfps_byte_if.sink     rx,
	rfps_result_if.source res,
	rfps_cfg_if.sink      cfg
);

	logic [LIMIT_W-1:0]  outlier_limit_q;
	logic [WEIGHT_W-1:0] smoothing_weight_q;

	frame_t              frame_s1;
	filt_status_t        filt_status;
	logic                res_valid;
	result_t             filt_res;
	result_t             head;
	logic [QCOUNT_W-1:0] q_count;
	logic [2:0]          pending;
	logic                byte_acc;

	// results that may still land in the queue
	assign pending  = 3'(q_count) + 3'(frame_s1.valid) + 3'(filt_status.s2)
		+ 3'(filt_status.s3) + 3'(filt_status.s4);
	assign rx.ready = (pending < 3'(QUEUE_DEPTH));
	assign byte_acc = rx.valid && rx.ready;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outlier_limit_q    <= LIMIT_RESET;
			smoothing_weight_q <= WEIGHT_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_OUTLIER_LIMIT:    outlier_limit_q    <= cfg.data[LIMIT_W-1:0];
				REG_SMOOTHING_WEIGHT: smoothing_weight_q <= cfg.data[WEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	rfps_parser #(
		.PAYLOAD_BYTES(PAYLOAD_BYTES)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_acc (byte_acc),
		.rx_byte  (rx.rx_byte),
		.frame_s1 (frame_s1)
	);

	rfps_filter #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_filter (
		.clk              (clk),
		.arst_n           (arst_n),
		.frame_s1         (frame_s1),
		.outlier_limit    (outlier_limit_q),
		.smoothing_weight (smoothing_weight_q),
		.res_valid        (res_valid),
		.res              (filt_res),
		.status           (filt_status)
	);

	rfps_result_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (filt_res),
		.pop       (res.ready),
		.not_empty (res.valid),
		.head      (head),
		.count     (q_count)
	);

	assign res.distance_mm       = head.distance_mm;
	assign res.distance_fraction = head.distance_fraction;
	assign res.outlier_dropped   = head.outlier_dropped;
	assign res.was_first_frame   = head.was_first_frame;

endmodule
